// ===== rtl/rcpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcpa_pkg;

  localparam int ADDR_W   = 56;
  localparam int BASE_W   = 44;
  localparam int TOP_W    = 45;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 45;

  localparam logic [BASE_W-1:0] BASE_RESET = 44'd524288;
  localparam logic [TOP_W-1:0]  TOP_RESET  = 45'd557056;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_ADDREF = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_OOM    = 3'd1,
    ST_BAD    = 3'd2,
    ST_DOUBLE = 3'd3,
    ST_HELD   = 3'd4,
    ST_SAT    = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_FRAME = 1'd0,
    REG_TOP_FRAME  = 1'd1
  } reg_index_t;

  // Checks on a byte address, produced by the decode stage.
  typedef struct packed {
    logic aligned;
    logic below_base;
  } dec_flags_t;

endpackage

`default_nettype wire

// ===== rtl/rcpa_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcpa_decode #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  wire                                  clk,
  input  wire                                  en,
  input  wire  [rcpa_pkg::ADDR_W-1:0]          address,
  input  wire  [rcpa_pkg::BASE_W-1:0]          base_frame,
  input  wire  [rcpa_pkg::TOP_W-1:0]           top_frame,
  output logic [$clog2(MAX_PAGES+1)-1:0]       n_pages,
  output logic [rcpa_pkg::ADDR_W-1:0]          offset,
  output rcpa_pkg::dec_flags_t                 flags
);

  localparam int NW         = $clog2(MAX_PAGES + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int AW         = rcpa_pkg::ADDR_W;

  logic [rcpa_pkg::TOP_W:0] span;
  logic [NW-1:0]            n_comb;
  logic [AW-1:0]            frame;
  logic [AW:0]              off_full;

  // Number of managed pages: top minus base, zero if empty or if top is below base, capped at the store depth.
  always_comb begin
    span = {1'b0, top_frame} - {2'b00, base_frame};
    if (span[rcpa_pkg::TOP_W] || span == '0) begin
      n_comb = '0;
    end else if (span > (rcpa_pkg::TOP_W + 1)'(MAX_PAGES)) begin
      n_comb = NW'(MAX_PAGES);
    end else begin
      n_comb = span[NW-1:0];
    end
  end

  // PAGE_BYTES is a power of two, so the frame is a plain shift.
  assign frame    = address >> PAGE_SHIFT;
  assign off_full = {1'b0, frame} - {{(AW + 1 - rcpa_pkg::BASE_W){1'b0}}, base_frame};

  always_ff @(posedge clk) begin
    if (en) begin
      n_pages          <= n_comb;
      offset           <= off_full[AW-1:0];
      flags.aligned    <= (address[PAGE_SHIFT-1:0] == '0);
      flags.below_base <= off_full[AW];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/refcounted_page_allocator.sv =====
// Flow: a request is taken in the idle state and passes through the decode, memory lookup
// and execute states; its result beat is registered in execute once the output can take it.
// No new request is taken until then; requests are serialized by the read-modify-write of
// the count and free-stack memories, each a single synchronous port pair with registered reads.
// Reset: synchronous; after it, a clearing pass zeroes all MAX_PAGES count entries,
// one per cycle, and no request is taken until it ends; configuration is taken at once.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_page_allocator #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  wire                                clk,
  input  wire                                rst,
  // Configuration write channel.
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [rcpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [rcpa_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Request channel.
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [rcpa_pkg::KIND_W-1:0]        kind,
  input  wire  [rcpa_pkg::ADDR_W-1:0]        address,
  // Result channel.
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [rcpa_pkg::ADDR_W-1:0]        page_address,
  output logic [rcpa_pkg::STATUS_W-1:0]      status,
  output logic [rcpa_pkg::COUNT_W-1:0]       count_after
);

  // Index width for the memories, and width of counters that can hold MAX_PAGES itself.
  localparam int IW         = $clog2(MAX_PAGES);
  localparam int NW         = $clog2(MAX_PAGES + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int AW         = rcpa_pkg::ADDR_W;
  localparam int CW         = rcpa_pkg::COUNT_W;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_DECODE = 5'b00100,
    S_LOOKUP = 5'b01000,
    S_EXEC   = 5'b10000
  } state_t;

  // What the execute cycle has to do, settled in the lookup cycle.
  typedef enum logic [2:0] {
    ACT_BAD    = 3'd0,
    ACT_OOM    = 3'd1,
    ACT_POP    = 3'd2,
    ACT_FRESH  = 3'd3,
    ACT_FREE   = 3'd4,
    ACT_ADDREF = 3'd5
  } act_t;

  state_t state, state_next;
  act_t   act, act_next;

  // Configuration registers.
  logic [rcpa_pkg::BASE_W-1:0] base_frame;
  logic [rcpa_pkg::TOP_W-1:0]  top_frame;

  // Latched request.
  logic [rcpa_pkg::KIND_W-1:0] kind_q;
  logic [AW-1:0]               address_q;

  // Allocator state held in flip-flops.
  logic [NW-1:0] stack_top;
  logic [NW-1:0] fresh_used;
  logic [IW-1:0] clr_addr;

  // The two memories: per-page counts and the LIFO of released page indices.
  logic [CW-1:0] count_mem [MAX_PAGES];
  logic [IW-1:0] stack_mem [MAX_PAGES];
  logic [CW-1:0] count_rd;
  logic [IW-1:0] stack_rd;

  // Decode stage outputs.
  logic [NW-1:0]        n_pages;
  logic [AW-1:0]        offset;
  rcpa_pkg::dec_flags_t flags;

  // Lookup cycle.
  logic          in_range;
  logic [IW-1:0] lookup_idx;
  logic [IW-1:0] idx_q;
  logic [NW-1:0] fresh_idx;
  logic [IW-1:0] pop_addr;

  // Execute cycle.
  logic                      commit;
  logic [IW-1:0]             alloc_idx;
  logic [rcpa_pkg::TOP_W-1:0] page_sum;
  logic [AW-1:0]             page_wide;
  logic [CW-1:0]             cnt_dec;
  logic [CW-1:0]             cnt_inc;
  logic                      cw_en;
  logic [IW-1:0]             cw_addr;
  logic [CW-1:0]             cw_data;
  logic                      sw_en;
  logic [AW-1:0]             res_page;
  logic [rcpa_pkg::STATUS_W-1:0] res_status;
  logic [CW-1:0]             res_count;
  logic [NW-1:0]             stack_top_next;
  logic [NW-1:0]             fresh_used_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  // A result is produced only when the output register is free or being drained.
  assign commit    = (state == S_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame <= rcpa_pkg::BASE_RESET;
      top_frame  <= rcpa_pkg::TOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rcpa_pkg::REG_BASE_FRAME: base_frame <= cfg_data[rcpa_pkg::BASE_W-1:0];
        rcpa_pkg::REG_TOP_FRAME:  top_frame  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_q    <= kind;
      address_q <= address;
    end
  end

  // Decode: alignment, offset from the base frame and the managed page count.
  rcpa_decode #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_decode (
    .clk        (clk),
    .en         (state == S_DECODE),
    .address    (address_q),
    .base_frame (base_frame),
    .top_frame  (top_frame),
    .n_pages    (n_pages),
    .offset     (offset),
    .flags      (flags)
  );

  // Lookup: pick the page and the action, and issue the memory reads.
  always_comb begin
    in_range   = flags.aligned && !flags.below_base && (offset < AW'(n_pages));
    lookup_idx = offset[IW-1:0];
    fresh_idx  = n_pages - NW'(1) - fresh_used;
    pop_addr   = IW'(stack_top - NW'(1));
    act_next   = ACT_BAD;
    case (kind_q)
      rcpa_pkg::KIND_ALLOC: begin
        // The most recently released page goes first; then the fresh fill, top down.
        if (stack_top != '0) begin
          act_next = ACT_POP;
        end else if (fresh_used < n_pages) begin
          act_next   = ACT_FRESH;
          lookup_idx = fresh_idx[IW-1:0];
        end else begin
          act_next = ACT_OOM;
        end
      end
      rcpa_pkg::KIND_FREE:   act_next = in_range ? ACT_FREE : ACT_BAD;
      rcpa_pkg::KIND_ADDREF: act_next = in_range ? ACT_ADDREF : ACT_BAD;
      default:               act_next = ACT_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_LOOKUP) begin
      act   <= act_next;
      idx_q <= lookup_idx;
      if (act_next == ACT_POP) begin
        stack_rd <= stack_mem[pop_addr];
      end
      if (act_next == ACT_FREE || act_next == ACT_ADDREF) begin
        count_rd <= count_mem[lookup_idx];
      end
    end
  end

  // Execute: form the result and the write-backs.
  always_comb begin
    alloc_idx       = (act == ACT_POP) ? stack_rd : idx_q;
    page_sum        = {1'b0, base_frame} + rcpa_pkg::TOP_W'(alloc_idx);
    // Bits shifted past the address field drop out, so the address wraps.
    page_wide       = AW'(page_sum) << PAGE_SHIFT;
    cnt_dec         = count_rd - CW'(1);
    cnt_inc         = count_rd + CW'(1);
    res_page        = '0;
    res_status      = rcpa_pkg::ST_BAD;
    res_count       = '0;
    cw_en           = 1'b0;
    cw_addr         = idx_q;
    cw_data         = '0;
    sw_en           = 1'b0;
    stack_top_next  = stack_top;
    fresh_used_next = fresh_used;
    case (act)
      ACT_POP, ACT_FRESH: begin
        res_page   = page_wide;
        res_status = rcpa_pkg::ST_OK;
        res_count  = CW'(1);
        cw_en      = 1'b1;
        cw_addr    = alloc_idx;
        cw_data    = CW'(1);
        if (act == ACT_POP) begin
          stack_top_next = stack_top - NW'(1);
        end else begin
          fresh_used_next = fresh_used + NW'(1);
        end
      end
      ACT_OOM: res_status = rcpa_pkg::ST_OOM;
      ACT_FREE: begin
        if (count_rd == '0) begin
          res_status = rcpa_pkg::ST_DOUBLE;
        end else begin
          cw_en     = 1'b1;
          cw_data   = cnt_dec;
          res_count = cnt_dec;
          if (cnt_dec == '0) begin
            res_status = rcpa_pkg::ST_OK;
            // A full stack can only follow a change of region at run time; the page is dropped.
            if (stack_top < NW'(MAX_PAGES)) begin
              sw_en          = 1'b1;
              stack_top_next = stack_top + NW'(1);
            end
          end else begin
            res_status = rcpa_pkg::ST_HELD;
          end
        end
      end
      ACT_ADDREF: begin
        if (count_rd == '0) begin
          res_status = rcpa_pkg::ST_BAD;
        end else if (count_rd == rcpa_pkg::COUNT_MAX) begin
          res_status = rcpa_pkg::ST_SAT;
          res_count  = rcpa_pkg::COUNT_MAX;
        end else begin
          res_status = rcpa_pkg::ST_OK;
          res_count  = cnt_inc;
          cw_en      = 1'b1;
          cw_data    = cnt_inc;
        end
      end
      default: res_status = rcpa_pkg::ST_BAD;
    endcase
  end

  // Count memory: one write port, shared by the clearing pass and the execute cycle.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      count_mem[clr_addr] <= '0;
    end else if (commit && cw_en) begin
      count_mem[cw_addr] <= cw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && sw_en) begin
      stack_mem[stack_top[IW-1:0]] <= idx_q;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_addr == IW'(MAX_PAGES - 1)) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: state_next = S_LOOKUP;
      S_LOOKUP: state_next = S_EXEC;
      S_EXEC:   if (commit) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      stack_top  <= '0;
      fresh_used <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + IW'(1);
      end
      if (commit) begin
        stack_top  <= stack_top_next;
        fresh_used <= fresh_used_next;
      end
    end
  end

  // Output register: the next request is taken while this beat waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      page_address <= res_page;
      status       <= res_status;
      count_after  <= res_count;
    end
  end

`ifndef SYNTHESIS
  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("request taken during clearing pass");

  a_commit_gives_beat: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("execute cycle did not produce a result beat");

  a_pop_shrinks_stack: assert property (@(posedge clk) disable iff (rst)
    (commit && act == ACT_POP) |=> (stack_top == $past(stack_top) - NW'(1)))
    else $error("stack pointer did not drop on a pop");

  a_double_free_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rcpa_pkg::ST_DOUBLE) |-> (count_after == '0 && page_address == '0))
    else $error("double free reported a count or an address");

  a_stack_bounded: assert property (@(posedge clk) disable iff (rst)
    (commit && sw_en) |-> (stack_top < NW'(MAX_PAGES)))
    else $error("push onto a full stack");
`endif

endmodule

`default_nettype wire
